/* design/sca5_pkg.sv */
// Shared types, constants and rounding helpers for the sin/cos fifth-harmonic block.
// Used by the front, back and top modules; depends on nothing.
package sca5_pkg;

  localparam int ADC_BITS_DEF    = 12;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int SAMPLE_W        = 12;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 2'd2;

  localparam logic signed [17:0] GAIN_Q15  = 18'sd26214;
  localparam logic signed [17:0] SCALE_Q15 = 18'sd26755;
  localparam logic signed [17:0] DAC_GAIN  = 18'sd2000;
  localparam logic [15:0]        MAG_FLOOR = 16'd3277;
  localparam logic signed [22:0] DAC_BIAS  = 23'sd16384;
  localparam logic [11:0]        DAC_MAX   = 12'd4095;

  typedef struct packed {
    logic [SAMPLE_W-1:0] cos_pos_sample;
    logic [SAMPLE_W-1:0] sin_pos_sample;
    logic [SAMPLE_W-1:0] cos_neg_sample;
    logic [SAMPLE_W-1:0] sin_neg_sample;
    logic [3:0]          ready_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cos_out;
    logic signed [15:0] sin_out;
    logic [11:0]        dac_code;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] xc;
    logic signed [15:0] xs;
  } diff_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FC, ST_FS, ST_FSU, ST_SQC, ST_SQS, ST_SQA, ST_SQRT,
    ST_DIVI, ST_DIV, ST_H0, ST_U2M, ST_U2, ST_U3M, ST_U3, ST_U5M, ST_T,
    ST_SCM, ST_SC, ST_R1M, ST_R2M, ST_R3M, ST_R4M, ST_R5, ST_DAC, ST_OUT
  } back_state_t;

  function automatic logic signed [41:0] rnd15(input logic signed [41:0] v);
    rnd15 = (v + 42'sd16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
    if (v > 42'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -42'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

/* design/sca5_fifo.sv */
// Small register queue between the front and back parts.
// Depends on nothing; width and depth come from the top level.
module sca5_fifo #(
  parameter int W     = 32,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/sca5_front.sv */
// Front part: accepts sample sets, applies ready mask and forms Q1.15 differences, negating the sine one when reversed.
// Depends on sca5_pkg; feeds sca5_fifo.
module sca5_front #(
  parameter int ADC_BITS = sca5_pkg::ADC_BITS_DEF
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sca5_pkg::in_item_t    in_data,
  input  logic                  reverse,
  input  logic                  q_full,
  output logic                  q_push,
  output sca5_pkg::diff_item_t  q_wdata
);
  localparam int SW = (ADC_BITS < sca5_pkg::SAMPLE_W) ? ADC_BITS : sca5_pkg::SAMPLE_W;
  localparam logic [sca5_pkg::SAMPLE_W-1:0] AMASK = sca5_pkg::SAMPLE_W'((1 << SW) - 1);
  localparam int LS = (ADC_BITS <= 15) ? 15 - ADC_BITS : 0;
  localparam int RS = (ADC_BITS > 15) ? ADC_BITS - 15 : 0;

  logic [sca5_pkg::SAMPLE_W-1:0] cp, sp, cn, sn;
  logic signed [17:0]            dc, ds;
  logic signed [15:0]            xc, xs;

  function automatic logic signed [15:0] to_q15(input logic signed [17:0] d);
    if (ADC_BITS <= 15) begin
      to_q15 = 16'(d <<< LS);
    end else if (d < 0) begin
      to_q15 = 16'(-((-d) >>> RS));
    end else begin
      to_q15 = 16'(d >>> RS);
    end
  endfunction

  always_comb begin
    cp = in_data.ready_mask[0] ? (in_data.cos_pos_sample & AMASK) : '0;
    sp = in_data.ready_mask[1] ? (in_data.sin_pos_sample & AMASK) : '0;
    cn = in_data.ready_mask[2] ? (in_data.cos_neg_sample & AMASK) : '0;
    sn = in_data.ready_mask[3] ? (in_data.sin_neg_sample & AMASK) : '0;
    dc = $signed(18'(cp)) - $signed(18'(cn));
    ds = $signed(18'(sp)) - $signed(18'(sn));
    xc = to_q15(dc);
    xs = to_q15(ds);
    q_wdata.xc = xc;
    q_wdata.xs = reverse ? -xs : xs;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

/* design/sca5_back.sv */
// Back part: filter, magnitude, normalize, fifth harmonic, rotation and DAC code.
// Depends on sca5_pkg; one shared multiplier driven by a sequencer.
module sca5_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sca5_pkg::diff_item_t q_rdata,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic signed [15:0]   offset_cos,
  input  logic signed [15:0]   offset_sin,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sca5_pkg::out_item_t  out_data
);
  sca5_pkg::back_state_t state_r, state_nxt;

  logic signed [15:0] xc_r, xs_r, fc_r, fs_r, co_r, so_r;
  logic signed [40:0] p_r, prod;
  logic signed [22:0] mul_a;
  logic signed [17:0] mul_b;
  logic [31:0]        sq_r, v_r;
  logic [32:0]        r_r, sqsum;
  logic [30:0]        bit_r;
  logic [15:0]        mag_r, remc_r, rems_r, absc, abss, magc;
  logic [19:0]        numc_r, nums_r, qc_r, qs_r;
  logic [16:0]        rem2c, rem2s;
  logic [4:0]         cnt_r;
  logic signed [16:0] uc_r, us_r, u2_r, u3_r, ul, difc, difs;
  logic signed [22:0] t_r, c5_r, s5_r, u5;
  logic signed [41:0] acc_r, pr;
  logic [11:0]        dac_r;
  logic               lane_r, load, out_valid_r;
  sca5_pkg::out_item_t out_data_r;

  function automatic logic signed [16:0] to_unit(input logic [19:0] q, input logic neg);
    logic [16:0] qs;
    qs = (q > 20'd32768) ? 17'd32768 : q[16:0];
    to_unit = neg ? -$signed(qs) : $signed(qs);
  endfunction

  assign ul    = lane_r ? us_r : uc_r;
  assign difc  = 17'(xc_r) - 17'(fc_r);
  assign difs  = 17'(xs_r) - 17'(fs_r);
  assign pr    = 42'(p_r);
  assign prod  = mul_a * mul_b;
  assign sqsum = r_r + 33'(bit_r);
  assign absc  = fc_r[15] ? 16'(-fc_r) : 16'(fc_r);
  assign abss  = fs_r[15] ? 16'(-fs_r) : 16'(fs_r);
  assign magc  = (r_r[15:0] <= sca5_pkg::MAG_FLOOR) ? sca5_pkg::MAG_FLOOR : r_r[15:0];
  assign rem2c = {remc_r, numc_r[19]};
  assign rem2s = {rems_r, nums_r[19]};
  assign u5    = 23'(sca5_pkg::rnd15(pr));
  assign load  = (state_r == sca5_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sca5_pkg::ST_IDLE: if (!q_empty) state_nxt = sca5_pkg::ST_FC;
      sca5_pkg::ST_FC:   state_nxt = sca5_pkg::ST_FS;
      sca5_pkg::ST_FS:   state_nxt = sca5_pkg::ST_FSU;
      sca5_pkg::ST_FSU:  state_nxt = sca5_pkg::ST_SQC;
      sca5_pkg::ST_SQC:  state_nxt = sca5_pkg::ST_SQS;
      sca5_pkg::ST_SQS:  state_nxt = sca5_pkg::ST_SQA;
      sca5_pkg::ST_SQA:  state_nxt = sca5_pkg::ST_SQRT;
      sca5_pkg::ST_SQRT: if (bit_r[0]) state_nxt = sca5_pkg::ST_DIVI;
      sca5_pkg::ST_DIVI: state_nxt = sca5_pkg::ST_DIV;
      sca5_pkg::ST_DIV:  if (cnt_r == '0) state_nxt = sca5_pkg::ST_H0;
      sca5_pkg::ST_H0:   state_nxt = sca5_pkg::ST_U2M;
      sca5_pkg::ST_U2M:  state_nxt = sca5_pkg::ST_U2;
      sca5_pkg::ST_U2:   state_nxt = sca5_pkg::ST_U3M;
      sca5_pkg::ST_U3M:  state_nxt = sca5_pkg::ST_U3;
      sca5_pkg::ST_U3:   state_nxt = sca5_pkg::ST_U5M;
      sca5_pkg::ST_U5M:  state_nxt = sca5_pkg::ST_T;
      sca5_pkg::ST_T:    state_nxt = sca5_pkg::ST_SCM;
      sca5_pkg::ST_SCM:  state_nxt = sca5_pkg::ST_SC;
      sca5_pkg::ST_SC:   state_nxt = lane_r ? sca5_pkg::ST_R1M : sca5_pkg::ST_U2M;
      sca5_pkg::ST_R1M:  state_nxt = sca5_pkg::ST_R2M;
      sca5_pkg::ST_R2M:  state_nxt = sca5_pkg::ST_R3M;
      sca5_pkg::ST_R3M:  state_nxt = sca5_pkg::ST_R4M;
      sca5_pkg::ST_R4M:  state_nxt = sca5_pkg::ST_R5;
      sca5_pkg::ST_R5:   state_nxt = sca5_pkg::ST_DAC;
      sca5_pkg::ST_DAC:  state_nxt = sca5_pkg::ST_OUT;
      sca5_pkg::ST_OUT:  if (load) state_nxt = sca5_pkg::ST_IDLE;
      default:           state_nxt = sca5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    q_pop = (state_r == sca5_pkg::ST_IDLE) && !q_empty;
    unique case (state_r)
      sca5_pkg::ST_FC:  begin mul_a = 23'(difc); mul_b = sca5_pkg::GAIN_Q15; end
      sca5_pkg::ST_FS:  begin mul_a = 23'(difs); mul_b = sca5_pkg::GAIN_Q15; end
      sca5_pkg::ST_SQC: begin mul_a = 23'(fc_r); mul_b = 18'(fc_r); end
      sca5_pkg::ST_SQS: begin mul_a = 23'(fs_r); mul_b = 18'(fs_r); end
      sca5_pkg::ST_U2M: begin mul_a = 23'(ul);   mul_b = 18'(ul); end
      sca5_pkg::ST_U3M: begin mul_a = 23'(u2_r); mul_b = 18'(ul); end
      sca5_pkg::ST_U5M: begin mul_a = 23'(u3_r); mul_b = 18'(u2_r); end
      sca5_pkg::ST_SCM: begin mul_a = t_r;       mul_b = sca5_pkg::SCALE_Q15; end
      sca5_pkg::ST_R1M: begin mul_a = c5_r;      mul_b = 18'(offset_cos); end
      sca5_pkg::ST_R2M: begin mul_a = s5_r;      mul_b = 18'(offset_sin); end
      sca5_pkg::ST_R3M: begin mul_a = s5_r;      mul_b = 18'(offset_cos); end
      sca5_pkg::ST_R4M: begin mul_a = c5_r;      mul_b = 18'(offset_sin); end
      sca5_pkg::ST_R5:  begin
        mul_a = 23'(co_r) + sca5_pkg::DAC_BIAS;
        mul_b = sca5_pkg::DAC_GAIN;
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sca5_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= '0;
      fs_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == sca5_pkg::ST_FS) begin
        fc_r <= sca5_pkg::sat16(42'(fc_r) + sca5_pkg::rnd15(pr));
      end
      if (state_r == sca5_pkg::ST_FSU) begin
        fs_r <= sca5_pkg::sat16(42'(fs_r) + sca5_pkg::rnd15(pr));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    unique case (state_r)
      sca5_pkg::ST_IDLE: begin
        xc_r <= q_rdata.xc;
        xs_r <= q_rdata.xs;
      end
      sca5_pkg::ST_SQS: sq_r <= p_r[31:0];
      sca5_pkg::ST_SQA: begin
        v_r   <= sq_r + p_r[31:0];
        r_r   <= '0;
        bit_r <= 31'h4000_0000;
      end
      sca5_pkg::ST_SQRT: begin
        if ({1'b0, v_r} >= sqsum) begin
          v_r <= 32'({1'b0, v_r} - sqsum);
          r_r <= (r_r >> 1) + 33'(bit_r);
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      sca5_pkg::ST_DIVI: begin
        mag_r  <= magc;
        remc_r <= 16'(absc[15:5]);
        rems_r <= 16'(abss[15:5]);
        numc_r <= {absc[4:0], 15'd0};
        nums_r <= {abss[4:0], 15'd0};
        qc_r   <= '0;
        qs_r   <= '0;
        cnt_r  <= 5'd19;
      end
      sca5_pkg::ST_DIV: begin
        if (rem2c >= {1'b0, mag_r}) begin
          remc_r <= 16'(rem2c - {1'b0, mag_r});
          qc_r   <= {qc_r[18:0], 1'b1};
        end else begin
          remc_r <= rem2c[15:0];
          qc_r   <= {qc_r[18:0], 1'b0};
        end
        if (rem2s >= {1'b0, mag_r}) begin
          rems_r <= 16'(rem2s - {1'b0, mag_r});
          qs_r   <= {qs_r[18:0], 1'b1};
        end else begin
          rems_r <= rem2s[15:0];
          qs_r   <= {qs_r[18:0], 1'b0};
        end
        numc_r <= numc_r << 1;
        nums_r <= nums_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      sca5_pkg::ST_H0: begin
        uc_r   <= to_unit(qc_r, fc_r[15]);
        us_r   <= to_unit(qs_r, fs_r[15]);
        lane_r <= 1'b0;
      end
      sca5_pkg::ST_U2: u2_r <= 17'(sca5_pkg::rnd15(pr));
      sca5_pkg::ST_U3: u3_r <= 17'(sca5_pkg::rnd15(pr));
      sca5_pkg::ST_T:  t_r <= (u5 <<< 4) - 23'sd20 * 23'(u3_r) + 23'sd5 * 23'(ul);
      sca5_pkg::ST_SC: begin
        if (lane_r) begin
          s5_r <= 23'(sca5_pkg::rnd15(pr));
        end else begin
          c5_r <= 23'(sca5_pkg::rnd15(pr));
        end
        lane_r <= 1'b1;
      end
      sca5_pkg::ST_R2M: acc_r <= pr;
      sca5_pkg::ST_R3M: co_r <= sca5_pkg::sat16(sca5_pkg::rnd15(acc_r + pr));
      sca5_pkg::ST_R4M: acc_r <= -pr;
      sca5_pkg::ST_R5:  so_r <= sca5_pkg::sat16(sca5_pkg::rnd15(acc_r + pr));
      sca5_pkg::ST_DAC: begin
        if (p_r < 0) begin
          dac_r <= '0;
        end else if ((p_r >>> 14) > 41'sd4095) begin
          dac_r <= sca5_pkg::DAC_MAX;
        end else begin
          dac_r <= p_r[25:14];
        end
      end
      default: begin end
    endcase
    if (load) begin
      out_data_r.cos_out  <= co_r;
      out_data_r.sin_out  <= so_r;
      out_data_r.dac_code <= dac_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/sincos_angle_fifth_harmonic_top.sv */
// A transaction goes from the queue to the back and then to the output register.
// The back takes no new transaction until the shared multiplier sequencer
// with its 16-step square root and 20-step divider has loaded the last result.
// The front accepts up to QUEUE_DEPTH transactions ahead while the back is busy.
// Reset (synchronous, rst_n low): filter state, offsets and direction clear to 0;
// queue and output register empty.
module sincos_angle_fifth_harmonic_top #(
  parameter int ADC_BITS    = sca5_pkg::ADC_BITS_DEF,
  parameter int QUEUE_DEPTH = sca5_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sca5_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sca5_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [sca5_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sca5_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  logic signed [15:0]   offset_cos_r, offset_sin_r;
  logic                 reverse_r;
  sca5_pkg::q_ctl_t     qc;
  sca5_pkg::diff_item_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_cos_r <= '0;
      offset_sin_r <= '0;
      reverse_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sca5_pkg::CFG_OFFSET_COS: offset_cos_r <= cfg_wdata;
        sca5_pkg::CFG_OFFSET_SIN: offset_sin_r <= cfg_wdata;
        sca5_pkg::CFG_REVERSE:    reverse_r    <= cfg_wdata[0];
        default: begin end
      endcase
    end
  end

  sca5_front #(.ADC_BITS(ADC_BITS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .reverse  (reverse_r),
    .q_full   (qc.full),
    .q_push   (qc.push),
    .q_wdata  (q_wdata)
  );

  sca5_fifo #(.W($bits(sca5_pkg::diff_item_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qc.push),
    .wdata (q_wdata),
    .pop   (qc.pop),
    .rdata (q_rdata),
    .full  (qc.full),
    .empty (qc.empty)
  );

  sca5_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_empty    (qc.empty),
    .q_pop      (qc.pop),
    .offset_cos (offset_cos_r),
    .offset_sin (offset_sin_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    qc.push |-> !qc.full) else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    qc.pop |-> !qc.empty) else $error("queue pop while empty");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid right after reset");

endmodule
